FILE: rtl/bfsp_pkg.sv
// shared widths, codes and control types for the shortest path block
package bfsp_pkg;

    localparam int CMD_W      = 1;
    localparam int SLOT_W     = 8;
    localparam int VTX_W      = 6;
    localparam int DIST_W     = 32;
    localparam int VCNT_W     = 7;
    localparam int ECNT_W     = 9;
    localparam int SRC_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CMD_W-1:0] CMD_STORE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 2'd2;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic store;
        logic init;
        logic edge_rd;
        logic dist_rd;
        logic relax;
        logic check;
        logic emit_rd;
        logic emit_load;
        logic neg_load;
    } bfsp_cmd_t;

    typedef struct packed {
        logic [VCNT_W-1:0] nv;
        logic [ECNT_W-1:0] ne;
        logic              found;
        logic              out_free;
    } bfsp_stat_t;

endpackage

FILE: rtl/bfsp_ctrl.sv
// sequencer for edge loading, relaxation passes, checking pass and result emission
module bfsp_ctrl #(
    parameter int VIDX_W = 6,
    parameter int EIDX_W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [bfsp_pkg::CMD_W-1:0] in_cmd,
    output logic                   in_ready,
    input  bfsp_pkg::bfsp_stat_t   stat,
    output bfsp_pkg::bfsp_cmd_t    cmd,
    output logic [EIDX_W-1:0]      edge_addr,
    output logic [VIDX_W-1:0]      vtx_addr
);
    import bfsp_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INIT    = 4'd1;
    localparam logic [3:0] ST_EDGE    = 4'd2;
    localparam logic [3:0] ST_DIST    = 4'd3;
    localparam logic [3:0] ST_RELAX   = 4'd4;
    localparam logic [3:0] ST_DECIDE  = 4'd5;
    localparam logic [3:0] ST_EMIT_RD = 4'd6;
    localparam logic [3:0] ST_EMIT_WR = 4'd7;
    localparam logic [3:0] ST_NEG     = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [ECNT_W-1:0] edge_reg, edge_next;
    logic [VCNT_W-1:0] pass_reg, pass_next;
    logic [VIDX_W-1:0] vtx_reg, vtx_next;

    logic is_check;
    logic last_edge;
    logic last_vtx;

    assign is_check  = (pass_reg == stat.nv);
    assign last_edge = (edge_reg == (stat.ne - 1'b1));
    assign last_vtx  = ((VCNT_W'(vtx_reg) + 1'b1) == stat.nv);

    assign in_ready  = (state_reg == ST_IDLE);
    assign edge_addr = EIDX_W'(edge_reg);
    assign vtx_addr  = vtx_reg;

    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        pass_next  = pass_reg;
        vtx_next   = vtx_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_STORE)
                    begin
                        cmd.store = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init  = 1'b1;
                edge_next = '0;
                pass_next = VCNT_W'(1);
                if (stat.ne == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.dist_rd = 1'b1;
                state_next  = ST_RELAX;
            end
            ST_RELAX:
            begin
                cmd.relax = !is_check;
                cmd.check = is_check;
                if (last_edge)
                begin
                    edge_next = '0;
                    if (is_check)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = ST_EDGE;
                    end
                end
                else
                begin
                    edge_next  = edge_reg + 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_DECIDE:
            begin
                vtx_next = '0;
                if (stat.found)
                begin
                    state_next = ST_NEG;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (last_vtx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        vtx_next   = vtx_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_NEG:
            begin
                if (stat.out_free)
                begin
                    cmd.neg_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= '0;
            pass_reg  <= '0;
            vtx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            pass_reg  <= pass_next;
            vtx_reg   <= vtx_next;
        end
    end

endmodule

FILE: rtl/bfsp_dpath.sv
// edge store, distance store, reach flags, relaxation arithmetic and output register
module bfsp_dpath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16,
    parameter int VIDX_W       = 6,
    parameter int EIDX_W       = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [bfsp_pkg::SLOT_W-1:0]         edge_slot,
    input  logic [bfsp_pkg::VTX_W-1:0]          edge_from,
    input  logic [bfsp_pkg::VTX_W-1:0]          edge_to,
    input  logic signed [WEIGHT_BITS-1:0]       edge_weight,
    input  bfsp_pkg::bfsp_cmd_t                 cmd,
    input  logic [EIDX_W-1:0]                   edge_addr,
    input  logic [VIDX_W-1:0]                   vtx_addr,
    output bfsp_pkg::bfsp_stat_t                stat,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [bfsp_pkg::VTX_W-1:0]          out_vertex,
    output logic signed [bfsp_pkg::DIST_W-1:0]  out_distance,
    output logic                                out_reachable,
    output logic                                out_negative_cycle,
    output logic                                out_last
);
    import bfsp_pkg::*;

    localparam int EDGE_W = 2 * VTX_W + WEIGHT_BITS;
    localparam int SUM_W  = DIST_W + 1;
    localparam int ECAP   = (MAX_EDGES < 512) ? MAX_EDGES : 511;

    logic [VCNT_W-1:0] vcount_reg;
    logic [ECNT_W-1:0] ecount_reg;
    logic [SRC_W-1:0]  source_reg;

    logic [EDGE_W-1:0]        edge_mem [MAX_EDGES];
    logic signed [DIST_W-1:0] dist_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  reach_reg;
    logic                     found_reg;

    logic [EDGE_W-1:0]        edge_q_reg;
    logic signed [DIST_W-1:0] dist_a_reg;
    logic signed [DIST_W-1:0] dist_b_reg;

    logic                     out_valid_reg;
    logic [VTX_W-1:0]         out_vertex_reg;
    logic signed [DIST_W-1:0] out_dist_reg;
    logic                     out_reach_reg;
    logic                     out_neg_reg;
    logic                     out_last_reg;

    logic [VCNT_W-1:0]        nv;
    logic [ECNT_W-1:0]        ne;
    logic [VTX_W-1:0]         e_from;
    logic [VTX_W-1:0]         e_to;
    logic signed [WEIGHT_BITS-1:0] e_weight;
    logic [VIDX_W-1:0]        u_idx;
    logic [VIDX_W-1:0]        v_idx;
    logic [VIDX_W-1:0]        rd_a_idx;
    logic                     in_range;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] cand;
    logic                     hit;
    logic                     src_ok;
    logic                     out_free;

    // effective counts
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            nv = VCNT_W'(1);
        end
        else if (vcount_reg > VCNT_W'(MAX_VERTICES))
        begin
            nv = VCNT_W'(MAX_VERTICES);
        end
        else
        begin
            nv = vcount_reg;
        end
        if (ecount_reg > ECNT_W'(ECAP))
        begin
            ne = ECNT_W'(ECAP);
        end
        else
        begin
            ne = ecount_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCNT_W'(1);
            ecount_reg <= '0;
            source_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERTEX_COUNT:  vcount_reg <= cfg_data[VCNT_W-1:0];
                REG_EDGE_COUNT:    ecount_reg <= cfg_data[ECNT_W-1:0];
                REG_SOURCE_VERTEX: source_reg <= cfg_data[SRC_W-1:0];
                default:           ;
            endcase
        end
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (cmd.store && (32'(edge_slot) < MAX_EDGES))
        begin
            edge_mem[EIDX_W'(edge_slot)] <= {edge_weight, edge_to, edge_from};
        end
        if (cmd.edge_rd)
        begin
            edge_q_reg <= edge_mem[edge_addr];
        end
    end

    assign e_from   = edge_q_reg[VTX_W-1:0];
    assign e_to     = edge_q_reg[2*VTX_W-1:VTX_W];
    assign e_weight = edge_q_reg[EDGE_W-1:2*VTX_W];
    assign u_idx    = VIDX_W'(e_from);
    assign v_idx    = VIDX_W'(e_to);
    assign in_range = ({1'b0, e_from} < nv) && ({1'b0, e_to} < nv);
    assign rd_a_idx = cmd.emit_rd ? vtx_addr : u_idx;
    assign src_ok   = ({1'b0, source_reg} < nv);

    // relaxation with saturation to the distance range
    assign sum = SUM_W'(dist_a_reg) + SUM_W'(e_weight);
    always_comb
    begin
        if (sum[SUM_W-1] != sum[SUM_W-2])
        begin
            cand = sum[SUM_W-1] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            cand = sum[DIST_W-1:0];
        end
    end
    assign hit = in_range && reach_reg[u_idx] && (!reach_reg[v_idx] || (cand < dist_b_reg));

    // distance store
    always_ff @(posedge clk)
    begin
        if (cmd.init && src_ok)
        begin
            dist_mem[VIDX_W'(source_reg)] <= '0;
        end
        else if (cmd.relax && hit)
        begin
            dist_mem[v_idx] <= cand;
        end
        if (cmd.dist_rd || cmd.emit_rd)
        begin
            dist_a_reg <= dist_mem[rd_a_idx];
        end
        if (cmd.dist_rd)
        begin
            dist_b_reg <= dist_mem[v_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.init)
        begin
            found_reg <= 1'b0;
            if (src_ok)
            begin
                reach_reg <= MAX_VERTICES'(1'b1) << source_reg;
            end
            else
            begin
                reach_reg <= '0;
            end
        end
        else
        begin
            if (cmd.relax && hit)
            begin
                reach_reg[v_idx] <= 1'b1;
            end
            if (cmd.check && hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.neg_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_vertex_reg <= VTX_W'(vtx_addr);
            out_dist_reg   <= reach_reg[vtx_addr] ? dist_a_reg : '0;
            out_reach_reg  <= reach_reg[vtx_addr];
            out_neg_reg    <= 1'b0;
            out_last_reg   <= ((VCNT_W'(vtx_addr) + 1'b1) == nv);
        end
        else if (cmd.neg_load)
        begin
            out_vertex_reg <= '0;
            out_dist_reg   <= '0;
            out_reach_reg  <= 1'b0;
            out_neg_reg    <= 1'b1;
            out_last_reg   <= 1'b1;
        end
    end

    assign stat.nv       = nv;
    assign stat.ne       = ne;
    assign stat.found    = found_reg;
    assign stat.out_free = out_free;

    assign out_valid          = out_valid_reg;
    assign out_vertex         = out_vertex_reg;
    assign out_distance       = out_dist_reg;
    assign out_reachable      = out_reach_reg;
    assign out_negative_cycle = out_neg_reg;
    assign out_last           = out_last_reg;

endmodule

FILE: rtl/bellman_ford_shortest_paths.sv
// top level of the single-source shortest path engine
//
// channel   direction  transaction
// s_axis    in         tuser 0: store edge from tdata, tuser 1: run
// m_axis    out        one result per vertex, or one negative cycle result; tlast on final
// cfg       in         register write: cfg_index selects, cfg_data holds value
//
// store: one edge a cycle while no run is in progress
// run: nv - 1 relaxation passes and one checking pass over the edges, then emission of the results
// each edge steps through the edge store read, distance store read and update
// rst_n clears control and reach flags; edge and distance stores are not cleared
// a stalled m_axis holds the emission sequence; s_axis is ready only between runs
module bellman_ford_shortest_paths #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // edge_slot, edge_from, edge_to, edge_weight, zero pad
    input  logic [((bfsp_pkg::SLOT_W + 2 * bfsp_pkg::VTX_W + WEIGHT_BITS + 7) / 8) * 8 - 1:0]
                                                s_axis_tdata,
    // cmd
    input  logic [bfsp_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // vertex, distance, zero pad
    output logic [((bfsp_pkg::VTX_W + bfsp_pkg::DIST_W + 7) / 8) * 8 - 1:0]
                                                m_axis_tdata,
    // reachable, negative_cycle
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bfsp_pkg::*;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int S_DATA_W = ((SLOT_W + 2 * VTX_W + WEIGHT_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((VTX_W + DIST_W + 7) / 8) * 8;
    localparam int FROM_LO  = SLOT_W;
    localparam int TO_LO    = SLOT_W + VTX_W;
    localparam int W_LO     = SLOT_W + 2 * VTX_W;

    bfsp_cmd_t  cmd;
    bfsp_stat_t stat;

    logic [EIDX_W-1:0]        edge_addr;
    logic [VIDX_W-1:0]        vtx_addr;
    logic [VTX_W-1:0]         out_vertex;
    logic signed [DIST_W-1:0] out_distance;
    logic                     out_reachable;
    logic                     out_negative_cycle;
    logic [S_DATA_W-1:0]      s_data;

    assign cfg_ready = 1'b1;
    assign s_data    = s_axis_tdata;

    bfsp_ctrl #(
        .VIDX_W (VIDX_W),
        .EIDX_W (EIDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd),
        .edge_addr (edge_addr),
        .vtx_addr  (vtx_addr)
    );

    bfsp_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .VIDX_W       (VIDX_W),
        .EIDX_W       (EIDX_W)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_valid & cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .edge_slot          (s_data[SLOT_W-1:0]),
        .edge_from          (s_data[FROM_LO +: VTX_W]),
        .edge_to            (s_data[TO_LO +: VTX_W]),
        .edge_weight        (s_data[W_LO +: WEIGHT_BITS]),
        .cmd                (cmd),
        .edge_addr          (edge_addr),
        .vtx_addr           (vtx_addr),
        .stat               (stat),
        .out_ready          (m_axis_tready),
        .out_valid          (m_axis_tvalid),
        .out_vertex         (out_vertex),
        .out_distance       (out_distance),
        .out_reachable      (out_reachable),
        .out_negative_cycle (out_negative_cycle),
        .out_last           (m_axis_tlast)
    );

    assign m_axis_tdata = M_DATA_W'({out_distance, out_vertex});
    assign m_axis_tuser = {out_negative_cycle, out_reachable};

endmodule
